FILE: rtl/core/vmis_pkg.sv
// ----------------------------------------------------------------------------
// vmis_pkg
// shared types and constants for the interpreter step core
// ----------------------------------------------------------------------------
package vmis_pkg;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_EXEC = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam int FONT_BYTES = 80;

    // 4x5 hex glyphs, five bytes per digit
    function automatic logic [7:0] font_byte(input logic [6:0] idx);
        logic [7:0] r;
        unique case (idx)
            7'd0:  r = 8'hF0; 7'd1:  r = 8'h90; 7'd2:  r = 8'h90; 7'd3:  r = 8'h90;
            7'd4:  r = 8'hF0; 7'd5:  r = 8'h20; 7'd6:  r = 8'h60; 7'd7:  r = 8'h20;
            7'd8:  r = 8'h20; 7'd9:  r = 8'h70; 7'd10: r = 8'hF0; 7'd11: r = 8'h10;
            7'd12: r = 8'hF0; 7'd13: r = 8'h80; 7'd14: r = 8'hF0; 7'd15: r = 8'hF0;
            7'd16: r = 8'h10; 7'd17: r = 8'hF0; 7'd18: r = 8'h10; 7'd19: r = 8'hF0;
            7'd20: r = 8'h90; 7'd21: r = 8'h90; 7'd22: r = 8'hF0; 7'd23: r = 8'h10;
            7'd24: r = 8'h10; 7'd25: r = 8'hF0; 7'd26: r = 8'h80; 7'd27: r = 8'hF0;
            7'd28: r = 8'h10; 7'd29: r = 8'hF0; 7'd30: r = 8'hF0; 7'd31: r = 8'h80;
            7'd32: r = 8'hF0; 7'd33: r = 8'h90; 7'd34: r = 8'hF0; 7'd35: r = 8'hF0;
            7'd36: r = 8'h10; 7'd37: r = 8'h20; 7'd38: r = 8'h40; 7'd39: r = 8'h40;
            7'd40: r = 8'hF0; 7'd41: r = 8'h90; 7'd42: r = 8'hF0; 7'd43: r = 8'h90;
            7'd44: r = 8'hF0; 7'd45: r = 8'hF0; 7'd46: r = 8'h90; 7'd47: r = 8'hF0;
            7'd48: r = 8'h10; 7'd49: r = 8'hF0; 7'd50: r = 8'hF0; 7'd51: r = 8'h90;
            7'd52: r = 8'hF0; 7'd53: r = 8'h90; 7'd54: r = 8'h90; 7'd55: r = 8'hE0;
            7'd56: r = 8'h90; 7'd57: r = 8'hE0; 7'd58: r = 8'h90; 7'd59: r = 8'hE0;
            7'd60: r = 8'hF0; 7'd61: r = 8'h80; 7'd62: r = 8'h80; 7'd63: r = 8'h80;
            7'd64: r = 8'hF0; 7'd65: r = 8'hE0; 7'd66: r = 8'h90; 7'd67: r = 8'h90;
            7'd68: r = 8'h90; 7'd69: r = 8'hE0; 7'd70: r = 8'hF0; 7'd71: r = 8'h80;
            7'd72: r = 8'hF0; 7'd73: r = 8'h80; 7'd74: r = 8'hF0; 7'd75: r = 8'hF0;
            7'd76: r = 8'h80; 7'd77: r = 8'hF0; 7'd78: r = 8'h80; 7'd79: r = 8'h80;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // memory port request from the sequencer
    typedef struct packed {
        logic        we;
        logic [11:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

endpackage

FILE: rtl/core/vm_instruction_step.sv
// ----------------------------------------------------------------------------
// vm_instruction_step
// interpreter cpu core: memory load, one instruction step, display row read
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  s_axis  | in  | tdata: mode, address, data, keys, random_byte, row
//  m_axis  | out | tdata: program_counter, flags, display_row
//
// each word runs through a small sequencer over one memory port and one
// display port. a load goes straight to the output, a read passes through
// the display read states and an instruction is fetched as two bytes and
// executed; a sprite draw loops once per row, fx55 and fx65 once per
// register and fx33 once per digit, so the longest word is a 15-row sprite.
// after reset the memory is cleared and the font written, one byte per
// cycle, before s_axis_tready rises. the result sits in an output register;
// a stall there holds the core.
// ----------------------------------------------------------------------------
module vm_instruction_step #(
    parameter int MEM_BYTES     = 4096,
    parameter int STACK_DEPTH   = 16,
    parameter int PROGRAM_START = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mode[1:0] address[13:2] data[21:14] keys[37:22] random_byte[45:38]
    // row[50:46], zero fill to 56
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // program_counter[11:0] draw_flag[12] sound_on[13] invalid_opcode[14]
    // waiting_key[15] display_row[79:16]
    output logic [79:0] m_axis_tdata
);
    import vmis_pkg::*;

    localparam int SPW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_F0, S_F1, S_F2, S_EXEC, S_DRW_A, S_DRW_B, S_DRW_C,
        S_BLK, S_BLK_R, S_BCD, S_RD, S_DONE
    } state_t;

    state_t      state_reg;
    mem_req_t    req;
    logic [7:0]  mem_rd;
    logic        init_done;

    logic        disp_clear, disp_we;
    logic [4:0]  disp_waddr, disp_raddr;
    logic [63:0] disp_wdata, disp_rd;

    logic [7:0]  v_reg [16];
    logic [11:0] stk_reg [STACK_DEPTH];
    logic [SPW-1:0] sp_reg;
    logic [11:0] pc_reg, idx_reg;
    logic [7:0]  dt_reg, st_reg;
    logic [15:0] op_reg;
    logic [15:0] keys_reg;
    logic [7:0]  rnd_reg;
    logic [1:0]  mode_reg;
    logic [4:0]  row_reg;
    logic [11:0] addr_reg;
    logic [7:0]  data_reg;
    logic [4:0]  k_reg;
    logic        hit_reg, drew_reg, bad_reg, wait_reg;
    logic [63:0] spr_reg, row_out_reg;
    logic [7:0]  bcd_reg;
    logic [7:0]  rem_reg;

    logic [3:0]  rx, ry, lo;
    logic [7:0]  nn, va, vb;
    logic [11:0] nnn;

    assign rx  = op_reg[11:8];
    assign ry  = op_reg[7:4];
    assign lo  = op_reg[3:0];
    assign nn  = op_reg[7:0];
    assign nnn = op_reg[11:0];
    assign va  = v_reg[rx];
    assign vb  = v_reg[ry];

    vmis_memory #(.MEM_BYTES(MEM_BYTES)) u_mem (
        .clk(clk), .rst_n(rst_n), .req(req), .rdata(mem_rd), .init_done(init_done)
    );

    vmis_display u_disp (
        .clk(clk), .rst_n(rst_n), .clear(disp_clear), .we(disp_we),
        .waddr(disp_waddr), .wdata(disp_wdata), .raddr(disp_raddr), .rdata(disp_rd)
    );

    // sprite row address and screen row
    logic [4:0]  drw_row;
    logic [5:0]  col;
    logic [63:0] spr_wide, spr_rot;
    assign drw_row  = vb[4:0] + k_reg[4:0];
    assign col      = va[5:0];
    assign spr_wide = {mem_rd, 56'd0};
    assign spr_rot  = (spr_wide >> col) | ((col == 6'd0) ? 64'd0 : (spr_wide << (7'd64 - {1'b0, col})));

    // tens and ones of the remainder below 100, x / 10 as (x * 205) >> 11
    logic [15:0] tens_prod;
    logic [7:0]  tens_q, ones_q;
    assign tens_prod = {8'd0, rem_reg} * 16'd205;
    assign tens_q    = {3'd0, tens_prod[15:11]};
    assign ones_q    = rem_reg - ((tens_q << 3) + (tens_q << 1));

    // memory and display port control
    always_comb
    begin
        req        = '0;
        disp_clear = 1'b0;
        disp_we    = 1'b0;
        disp_waddr = drw_row;
        disp_wdata = disp_rd ^ spr_reg;
        disp_raddr = drw_row;
        unique case (state_reg)
            S_IDLE:  req.addr = pc_reg;
            S_F0:    req.addr = pc_reg;
            S_F1:    req.addr = pc_reg + 12'd1;
            S_DRW_A: req.addr = idx_reg + {7'd0, k_reg};
            S_BLK:
            begin
                req.addr  = idx_reg + {7'd0, k_reg};
                req.we    = (nn == 8'h55);
                req.wdata = v_reg[k_reg[3:0]];
            end
            S_BCD:
            begin
                req.addr  = idx_reg + {10'd0, k_reg[1:0]};
                req.we    = 1'b1;
                req.wdata = bcd_reg;
            end
            S_RD:    disp_raddr = row_reg;
            S_DRW_C: disp_we = 1'b1;
            S_EXEC:  disp_clear = (op_reg == 16'h00E0);
            default: req.addr = addr_reg;
        endcase
        if (state_reg == S_DONE && mode_reg == MODE_LOAD && !m_axis_tvalid)
        begin
            req.we    = 1'b1;
            req.addr  = addr_reg;
            req.wdata = data_reg;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE) && init_done && !m_axis_tvalid;

    logic [12:0] sum_i;
    assign sum_i = {1'b0, idx_reg} + {5'd0, va};
    logic [8:0]  add_ab;
    assign add_ab = {1'b0, va} + {1'b0, vb};

    logic [4:0] first_key;
    always_comb
    begin
        first_key = 5'd16;
        for (int i = 15; i >= 0; i--)
            if (keys_reg[i]) first_key = 5'(i);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            m_axis_tvalid <= 1'b0;
            sp_reg        <= '0;
            pc_reg        <= 12'(PROGRAM_START);
            idx_reg       <= '0;
            dt_reg        <= '0;
            st_reg        <= '0;
            for (int i = 0; i < 16; i++) v_reg[i] <= '0;
            for (int i = 0; i < STACK_DEPTH; i++) stk_reg[i] <= '0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                m_axis_tvalid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        mode_reg <= s_axis_tdata[1:0];
                        addr_reg <= s_axis_tdata[13:2];
                        data_reg <= s_axis_tdata[21:14];
                        keys_reg <= s_axis_tdata[37:22];
                        rnd_reg  <= s_axis_tdata[45:38];
                        row_reg  <= s_axis_tdata[50:46];
                        drew_reg <= 1'b0;
                        bad_reg  <= 1'b0;
                        wait_reg <= 1'b0;
                        hit_reg  <= 1'b0;
                        k_reg    <= '0;
                        row_out_reg <= '0;
                        if (s_axis_tdata[1:0] == MODE_EXEC)
                            state_reg <= S_F0;
                        else if (s_axis_tdata[1:0] == MODE_READ)
                            state_reg <= S_RD;
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_F0: state_reg <= S_F1;
                S_F1:
                begin
                    op_reg[15:8] <= mem_rd;
                    state_reg    <= S_F2;
                end
                S_F2:
                begin
                    op_reg[7:0] <= mem_rd;
                    state_reg   <= S_EXEC;
                end
                S_RD: state_reg <= S_BLK_R;
                S_BLK_R:
                begin
                    if (mode_reg == MODE_READ)
                    begin
                        row_out_reg <= disp_rd;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        // fx65 data arrives in the cycle after its address
                        v_reg[k_reg[3:0]] <= mem_rd;
                        if (k_reg[3:0] == rx)
                        begin
                            idx_reg   <= idx_reg + {8'd0, rx} + 12'd1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 5'd1;
                            state_reg <= S_BLK;
                        end
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_DONE;
                    pc_reg    <= pc_reg + 12'd2;
                    unique case (op_reg[15:12])
                        4'h0:
                        begin
                            if (op_reg == 16'h00E0)
                                drew_reg <= 1'b1;
                            else if (op_reg == 16'h00EE)
                            begin
                                if (sp_reg == '0)
                                begin
                                    sp_reg <= SPW'(STACK_DEPTH - 1);
                                    pc_reg <= stk_reg[STACK_DEPTH - 1] + 12'd2;
                                end
                                else
                                begin
                                    sp_reg <= sp_reg - 1'b1;
                                    pc_reg <= stk_reg[sp_reg - 1'b1] + 12'd2;
                                end
                            end
                            else
                            begin
                                bad_reg <= 1'b1;
                                pc_reg  <= pc_reg;
                            end
                        end
                        4'h1: pc_reg <= nnn;
                        4'h2:
                        begin
                            stk_reg[sp_reg] <= pc_reg;
                            sp_reg <= ({1'b0, sp_reg} + 1'b1 >= (SPW+1)'(STACK_DEPTH))
                                      ? '0 : sp_reg + 1'b1;
                            pc_reg <= nnn;
                        end
                        4'h3: if (va == nn) pc_reg <= pc_reg + 12'd4;
                        4'h4: if (va != nn) pc_reg <= pc_reg + 12'd4;
                        4'h5: if (va == vb) pc_reg <= pc_reg + 12'd4;
                        4'h6: v_reg[rx] <= nn;
                        4'h7: v_reg[rx] <= va + nn;
                        4'h8:
                        begin
                            unique case (lo)
                                4'h0: v_reg[rx] <= vb;
                                4'h1: v_reg[rx] <= va | vb;
                                4'h2: v_reg[rx] <= va & vb;
                                4'h3: v_reg[rx] <= va ^ vb;
                                4'h4:
                                begin
                                    v_reg[rx] <= add_ab[7:0];
                                    v_reg[15] <= {7'd0, add_ab[8]};
                                end
                                4'h5:
                                begin
                                    v_reg[rx] <= va - vb;
                                    v_reg[15] <= {7'd0, va >= vb};
                                end
                                4'h6:
                                begin
                                    v_reg[rx] <= {1'b0, va[7:1]};
                                    v_reg[15] <= {7'd0, va[0]};
                                end
                                4'h7:
                                begin
                                    v_reg[rx] <= vb - va;
                                    v_reg[15] <= {7'd0, vb >= va};
                                end
                                4'hE:
                                begin
                                    v_reg[rx] <= {va[6:0], 1'b0};
                                    v_reg[15] <= {7'd0, va[7]};
                                end
                                default:
                                begin
                                    bad_reg <= 1'b1;
                                    pc_reg  <= pc_reg;
                                end
                            endcase
                        end
                        4'h9: if (va != vb) pc_reg <= pc_reg + 12'd4;
                        4'hA: idx_reg <= nnn;
                        4'hB: pc_reg <= nnn + {4'd0, v_reg[0]};
                        4'hC: v_reg[rx] <= rnd_reg & nn;
                        4'hD:
                        begin
                            drew_reg <= 1'b1;
                            if (lo != 4'd0)
                                state_reg <= S_DRW_A;
                            else
                                v_reg[15] <= 8'd0;
                        end
                        4'hE:
                        begin
                            if (nn == 8'h9E)
                            begin
                                if (keys_reg[va[3:0]]) pc_reg <= pc_reg + 12'd4;
                            end
                            else if (nn == 8'hA1)
                            begin
                                if (!keys_reg[va[3:0]]) pc_reg <= pc_reg + 12'd4;
                            end
                            else
                            begin
                                bad_reg <= 1'b1;
                                pc_reg  <= pc_reg;
                            end
                        end
                        default:
                        begin
                            priority case (nn)
                                8'h07: v_reg[rx] <= dt_reg;
                                8'h0A:
                                begin
                                    if (first_key[4])
                                    begin
                                        wait_reg <= 1'b1;
                                        pc_reg   <= pc_reg;
                                    end
                                    else
                                        v_reg[rx] <= {4'd0, first_key[3:0]};
                                end
                                8'h15: dt_reg <= va;
                                8'h18: st_reg <= va;
                                8'h1E:
                                begin
                                    v_reg[15] <= {7'd0, sum_i[12]};
                                    idx_reg   <= sum_i[11:0];
                                end
                                8'h29: idx_reg <= {6'd0, va[3:0], 2'b00} + {8'd0, va[3:0]};
                                8'h33:
                                begin
                                    // hundreds first; tens and ones follow
                                    bcd_reg   <= (va >= 8'd200) ? 8'd2 : (va >= 8'd100) ? 8'd1 : 8'd0;
                                    rem_reg   <= (va >= 8'd200) ? va - 8'd200 :
                                                 (va >= 8'd100) ? va - 8'd100 : va;
                                    state_reg <= S_BCD;
                                end
                                8'h55: state_reg <= S_BLK;
                                8'h65: state_reg <= S_BLK;
                                default:
                                begin
                                    bad_reg <= 1'b1;
                                    pc_reg  <= pc_reg;
                                end
                            endcase
                        end
                    endcase
                end
                S_DRW_A: state_reg <= S_DRW_B;
                S_DRW_B:
                begin
                    // sprite byte and display row both ready
                    spr_reg   <= spr_rot;
                    if ((disp_rd & spr_rot) != 64'd0) hit_reg <= 1'b1;
                    state_reg <= S_DRW_C;
                end
                S_DRW_C:
                begin
                    if (k_reg[3:0] == lo - 4'd1)
                    begin
                        v_reg[15] <= {7'd0, hit_reg};
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 5'd1;
                        state_reg <= S_DRW_A;
                    end
                end
                S_BCD:
                begin
                    // one digit per cycle from the remainder
                    if (k_reg[1:0] == 2'd0)
                    begin
                        bcd_reg <= tens_q;
                        k_reg   <= 5'd1;
                    end
                    else if (k_reg[1:0] == 2'd1)
                    begin
                        bcd_reg <= ones_q;
                        k_reg   <= 5'd2;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_BLK:
                begin
                    if (nn == 8'h55)
                    begin
                        if (k_reg[3:0] == rx)
                        begin
                            idx_reg   <= idx_reg + {8'd0, rx} + 12'd1;
                            state_reg <= S_DONE;
                        end
                        else
                            k_reg <= k_reg + 5'd1;
                    end
                    else
                        state_reg <= S_BLK_R;
                end
                S_DONE:
                begin
                    if (!m_axis_tvalid)
                    begin
                        if (mode_reg == MODE_EXEC)
                        begin
                            dt_reg <= (dt_reg != 8'd0) ? dt_reg - 8'd1 : dt_reg;
                            st_reg <= (st_reg != 8'd0) ? st_reg - 8'd1 : st_reg;
                            m_axis_tdata[13] <= (st_reg > 8'd1);
                        end
                        else
                            m_axis_tdata[13] <= (st_reg != 8'd0);
                        m_axis_tdata[11:0]  <= pc_reg;
                        m_axis_tdata[12]    <= drew_reg;
                        m_axis_tdata[14]    <= bad_reg;
                        m_axis_tdata[15]    <= wait_reg;
                        m_axis_tdata[79:16] <= row_out_reg;
                        m_axis_tvalid       <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/vmis_memory.sv
// ----------------------------------------------------------------------------
// vmis_memory
// 4 KiB byte memory, one port, registered read; clears and loads the font
// after reset
// ----------------------------------------------------------------------------
module vmis_memory #(
    parameter int MEM_BYTES = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  vmis_pkg::mem_req_t req,
    output logic [7:0]        rdata,
    output logic              init_done
);
    import vmis_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    logic [7:0]  mem [MEM_BYTES];
    logic [AW:0] init_cnt_reg;

    assign init_done = init_cnt_reg[AW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cnt_reg <= '0;
        end
        else if (!init_cnt_reg[AW])
        begin
            init_cnt_reg <= init_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!init_done)
        begin
            if (init_cnt_reg[AW-1:0] < AW'(FONT_BYTES))
                mem[init_cnt_reg[AW-1:0]] <= font_byte(init_cnt_reg[6:0]);
            else
                mem[init_cnt_reg[AW-1:0]] <= 8'h00;
        end
        else if (req.we)
        begin
            mem[req.addr[AW-1:0]] <= req.wdata;
        end
        rdata <= mem[req.addr[AW-1:0]];
    end

endmodule

FILE: rtl/core/vmis_display.sv
// ----------------------------------------------------------------------------
// vmis_display
// 32 rows of 64 pixels, one row read and one written per cycle, with a
// per-row valid bit so reset and screen clear take effect at once
// ----------------------------------------------------------------------------
module vmis_display (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clear,
    input  logic        we,
    input  logic [4:0]  waddr,
    input  logic [63:0] wdata,
    input  logic [4:0]  raddr,
    output logic [63:0] rdata
);
    logic [63:0] rows [32];
    logic [31:0] valid_reg;
    logic [63:0] raw_q;
    logic        vld_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_q     <= 1'b0;
        end
        else
        begin
            vld_q <= valid_reg[raddr] && !clear;
            if (clear)
                valid_reg <= '0;
            else if (we)
                valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            rows[waddr] <= wdata;
        raw_q <= rows[raddr];
    end

    assign rdata = vld_q ? raw_q : 64'd0;

endmodule
